/* rtl/vte_pkg.sv */
// ----------------------------------------------------------------------------
// vte_pkg: shared types, constants and microprogram
// Control word layout, filter coefficients and the step table used by the
// sequencer and the datapath of the vocal tone enhancer.
// ----------------------------------------------------------------------------
package vte_pkg;

  // Default widths
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int STATE_BITS_DEF  = 24;

  // Amount registers, Q1.16 with 1.0 at 65536
  localparam int             AMT_W     = 17;
  localparam logic [AMT_W-1:0] AMT_ONE = 17'h10000;
  localparam int             CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WARMTH   = 2'd0,
    REG_PRESENCE = 2'd1,
    REG_AIR      = 2'd2
  } reg_idx_e;

  // Fixed point: coefficients are Q0.16 held in an 18-bit signed operand
  localparam int COEF_W     = 18;
  localparam int FRAC_BITS  = 16;
  localparam int ROUND_HALF = 32768;

  localparam logic signed [COEF_W-1:0] C_W_KEEP  = 18'sd62259;
  localparam logic signed [COEF_W-1:0] C_W_IN    = 18'sd3277;
  localparam logic signed [COEF_W-1:0] C_W_GAIN  = 18'sd19661;
  localparam logic signed [COEF_W-1:0] C_PA_KEEP = 18'sd52429;
  localparam logic signed [COEF_W-1:0] C_PA_IN   = 18'sd13107;
  localparam logic signed [COEF_W-1:0] C_PB_KEEP = 18'sd39322;
  localparam logic signed [COEF_W-1:0] C_PB_IN   = 18'sd26214;
  localparam logic signed [COEF_W-1:0] C_P_GAIN  = 18'sd32768;
  localparam logic signed [COEF_W-1:0] C_A_KEEP  = 18'sd58982;
  localparam logic signed [COEF_W-1:0] C_A_IN    = 18'sd6554;
  localparam logic signed [COEF_W-1:0] C_A_GAIN  = 18'sd13107;

  // Multiplier / accumulator operation
  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_LOAD = 2'd1,
    MUL_ADD  = 2'd2
  } mul_e;

  // Multiplier operand A
  typedef enum logic [2:0] {
    A_WL    = 3'd0,
    A_PA    = 3'd1,
    A_PB    = 3'd2,
    A_AL    = 3'd3,
    A_S     = 3'd4,
    A_PDIFF = 3'd5,
    A_RES   = 3'd6,
    A_T     = 3'd7
  } asel_e;

  // Multiplier operand B
  typedef enum logic [3:0] {
    B_W_KEEP  = 4'd0,
    B_W_IN    = 4'd1,
    B_W_GAIN  = 4'd2,
    B_PA_KEEP = 4'd3,
    B_PA_IN   = 4'd4,
    B_PB_KEEP = 4'd5,
    B_PB_IN   = 4'd6,
    B_P_GAIN  = 4'd7,
    B_A_KEEP  = 4'd8,
    B_A_IN    = 4'd9,
    B_A_GAIN  = 4'd10,
    B_AMT_W   = 4'd11,
    B_AMT_P   = 4'd12,
    B_AMT_A   = 4'd13
  } bsel_e;

  // Write-back of the rounded accumulator
  typedef enum logic [2:0] {
    WB_NONE = 3'd0,
    WB_WL   = 3'd1,
    WB_PA   = 3'd2,
    WB_PB   = 3'd3,
    WB_AL   = 3'd4,
    WB_T    = 3'd5,
    WB_S    = 3'd6
  } wb_e;

  // Sequencing
  typedef enum logic [2:0] {
    SQ_NEXT    = 3'd0,
    SQ_JZ_WARM = 3'd1,
    SQ_JZ_PRES = 3'd2,
    SQ_JZ_AIR  = 3'd3,
    SQ_END     = 3'd4
  } seq_e;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_W0  = 5'd0;
  localparam logic [PC_W-1:0] PC_P0  = 5'd7;
  localparam logic [PC_W-1:0] PC_A0  = 5'd16;
  localparam logic [PC_W-1:0] PC_END = 5'd21;

  typedef struct packed {
    mul_e            mul;
    asel_e           asel;
    bsel_e           bsel;
    wb_e             wb;
    seq_e            seq;
    logic [PC_W-1:0] target;
  } cw_t;

  typedef struct packed {
    logic warmth;
    logic presence;
    logic air;
  } amt_zero_t;

  localparam cw_t CW_NOP = '{mul: MUL_NONE, asel: A_WL, bsel: B_W_KEEP, wb: WB_NONE,
                             seq: SQ_NEXT, target: PC_W0};

  function automatic cw_t mk_cw(mul_e m, asel_e a, bsel_e b, wb_e w, seq_e q,
                                logic [PC_W-1:0] tgt);
    cw_t c;
    c.mul    = m;
    c.asel   = a;
    c.bsel   = b;
    c.wb     = w;
    c.seq    = q;
    c.target = tgt;
    return c;
  endfunction

  // Microprogram. Write-back in a step uses the accumulator left by the
  // previous step; operands read registers before that step's write-back.
  function automatic cw_t prog_word(logic [PC_W-1:0] pc);
    cw_t c;
    c = CW_NOP;
    unique case (pc)
      // warmth: wl = upd(wl, s); s += R(R(wl*amt)*gain)
      5'd0:  c = mk_cw(MUL_LOAD, A_WL,    B_W_KEEP,  WB_NONE, SQ_JZ_WARM, PC_P0);
      5'd1:  c = mk_cw(MUL_ADD,  A_S,     B_W_IN,    WB_NONE, SQ_NEXT,    PC_W0);
      5'd2:  c = mk_cw(MUL_NONE, A_WL,    B_W_KEEP,  WB_WL,   SQ_NEXT,    PC_W0);
      5'd3:  c = mk_cw(MUL_LOAD, A_WL,    B_AMT_W,   WB_NONE, SQ_NEXT,    PC_W0);
      5'd4:  c = mk_cw(MUL_NONE, A_WL,    B_W_KEEP,  WB_T,    SQ_NEXT,    PC_W0);
      5'd5:  c = mk_cw(MUL_LOAD, A_T,     B_W_GAIN,  WB_NONE, SQ_NEXT,    PC_W0);
      5'd6:  c = mk_cw(MUL_NONE, A_WL,    B_W_KEEP,  WB_S,    SQ_NEXT,    PC_W0);
      // presence: two chained lowpasses, add scaled difference
      5'd7:  c = mk_cw(MUL_LOAD, A_PA,    B_PA_KEEP, WB_NONE, SQ_JZ_PRES, PC_A0);
      5'd8:  c = mk_cw(MUL_ADD,  A_S,     B_PA_IN,   WB_NONE, SQ_NEXT,    PC_W0);
      5'd9:  c = mk_cw(MUL_LOAD, A_PB,    B_PB_KEEP, WB_PA,   SQ_NEXT,    PC_W0);
      5'd10: c = mk_cw(MUL_ADD,  A_PA,    B_PB_IN,   WB_NONE, SQ_NEXT,    PC_W0);
      5'd11: c = mk_cw(MUL_NONE, A_WL,    B_W_KEEP,  WB_PB,   SQ_NEXT,    PC_W0);
      5'd12: c = mk_cw(MUL_LOAD, A_PDIFF, B_AMT_P,   WB_NONE, SQ_NEXT,    PC_W0);
      5'd13: c = mk_cw(MUL_NONE, A_WL,    B_W_KEEP,  WB_T,    SQ_NEXT,    PC_W0);
      5'd14: c = mk_cw(MUL_LOAD, A_T,     B_P_GAIN,  WB_NONE, SQ_NEXT,    PC_W0);
      5'd15: c = mk_cw(MUL_NONE, A_WL,    B_W_KEEP,  WB_S,    SQ_NEXT,    PC_W0);
      // air: residue against the old lowpass, then update the lowpass
      5'd16: c = mk_cw(MUL_LOAD, A_RES,   B_AMT_A,   WB_NONE, SQ_JZ_AIR,  PC_END);
      5'd17: c = mk_cw(MUL_LOAD, A_AL,    B_A_KEEP,  WB_T,    SQ_NEXT,    PC_W0);
      5'd18: c = mk_cw(MUL_ADD,  A_S,     B_A_IN,    WB_NONE, SQ_NEXT,    PC_W0);
      5'd19: c = mk_cw(MUL_LOAD, A_T,     B_A_GAIN,  WB_AL,   SQ_NEXT,    PC_W0);
      5'd20: c = mk_cw(MUL_NONE, A_WL,    B_W_KEEP,  WB_S,    SQ_NEXT,    PC_W0);
      // hand the saturated sample to the output register
      5'd21: c = mk_cw(MUL_NONE, A_WL,    B_W_KEEP,  WB_NONE, SQ_END,     PC_W0);
      default: c = mk_cw(MUL_NONE, A_WL,  B_W_KEEP,  WB_NONE, SQ_END,     PC_W0);
    endcase
    return c;
  endfunction

endpackage

/* rtl/vte_if.sv */
// ----------------------------------------------------------------------------
// vte_if: sample stream channels
// Input and output channels with valid/ready handshake and sample payload.
// ----------------------------------------------------------------------------
interface vte_in_if import vte_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          frame_last;

  modport source (output valid, output sample_in, output frame_last, input ready);
  modport sink   (input valid, input sample_in, input frame_last, output ready);
endinterface

interface vte_out_if import vte_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          out_last;

  modport source (output valid, output sample_out, output out_last, input ready);
  modport sink   (input valid, input sample_out, input out_last, output ready);
endinterface

/* rtl/vte_sat.sv */
// ----------------------------------------------------------------------------
// vte_sat: signed saturation
// Clamps a signed value to the range of a narrower (or equal) signed width.
// ----------------------------------------------------------------------------
module vte_sat #(
  parameter int IN_W  = 32,
  parameter int OUT_W = 16
) (
  input  logic signed [IN_W-1:0]  x_i,
  output logic signed [OUT_W-1:0] y_o
);
  localparam int TOP_W = IN_W - OUT_W + 1;

  logic [TOP_W-1:0] top_bits;
  logic             in_range;

  // in range when all bits from the target sign bit upward agree
  assign top_bits = x_i[IN_W-1:OUT_W-1];
  assign in_range = (top_bits == '0) || (top_bits == '1);
  assign y_o      = in_range ? x_i[OUT_W-1:0]
                             : {x_i[IN_W-1], {(OUT_W-1){~x_i[IN_W-1]}}};
endmodule

/* rtl/vte_sequencer.sv */
// ----------------------------------------------------------------------------
// vte_sequencer: microprogram control
// Step counter over the control store, conditional stage skips and the
// input/output handshake timing.
// ----------------------------------------------------------------------------
module vte_sequencer import vte_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_free_i,
  input  amt_zero_t amt_zero_i,
  output logic      in_ready_o,
  output cw_t       ctrl_o,
  output logic      out_load_o
);
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic [PC_W-1:0] pc_inc;
  cw_t             cw;

  assign cw         = prog_word(pc_q);
  assign pc_inc     = PC_W'(pc_q + 1'b1);
  assign in_ready_o = (state_q == ST_IDLE);

  // next step and control word
  always_comb begin
    state_d    = state_q;
    pc_d       = pc_q;
    ctrl_o     = CW_NOP;
    out_load_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
          pc_d    = PC_W0;
        end
      end
      ST_RUN: begin
        ctrl_o = cw;
        unique case (cw.seq)
          SQ_NEXT:    pc_d = pc_inc;
          SQ_JZ_WARM: pc_d = amt_zero_i.warmth   ? cw.target : pc_inc;
          SQ_JZ_PRES: pc_d = amt_zero_i.presence ? cw.target : pc_inc;
          SQ_JZ_AIR:  pc_d = amt_zero_i.air      ? cw.target : pc_inc;
          SQ_END: begin
            // wait for the output register to free up
            if (out_free_i) begin
              out_load_o = 1'b1;
              state_d    = ST_IDLE;
            end
          end
          default: pc_d = pc_inc;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= PC_W0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end
endmodule

/* rtl/vte_datapath.sv */
// ----------------------------------------------------------------------------
// vte_datapath: shared multiply-accumulate datapath
// One signed multiplier with accumulator, rounding and saturating write-back
// into the filter states and the running sample, and a rounded temporary.
// ----------------------------------------------------------------------------
module vte_datapath import vte_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int STATE_BITS  = STATE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [AMT_W-1:0]              amt_warmth_i,
  input  logic [AMT_W-1:0]              amt_presence_i,
  input  logic [AMT_W-1:0]              amt_air_i,
  input  cw_t                           ctrl_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);
  localparam int RUN_W  = (SAMPLE_BITS > STATE_BITS) ? SAMPLE_BITS : STATE_BITS;
  localparam int OPA_W  = RUN_W + 2;
  localparam int PROD_W = OPA_W + COEF_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int RND_W  = ACC_W - FRAC_BITS;
  localparam int SUM_W  = RND_W + 1;

  logic signed [RUN_W-1:0]      s_q, s_d;
  logic signed [OPA_W-1:0]      t_q, t_d;
  logic signed [ACC_W-1:0]      acc_q, acc_d;
  logic signed [STATE_BITS-1:0] wl_q, wl_d, pa_q, pa_d, pb_q, pb_d, al_q, al_d;

  logic signed [OPA_W-1:0]      a_op;
  logic signed [COEF_W-1:0]     b_op;
  logic signed [PROD_W-1:0]     prod;
  logic signed [ACC_W-1:0]      acc_half;
  logic signed [RND_W-1:0]      rnd;
  logic signed [SUM_W-1:0]      s_sum;
  logic signed [STATE_BITS-1:0] filt_sat;
  logic signed [STATE_BITS-1:0] sum_sat;

  // operand A
  always_comb begin
    unique case (ctrl_i.asel)
      A_WL:    a_op = OPA_W'(wl_q);
      A_PA:    a_op = OPA_W'(pa_q);
      A_PB:    a_op = OPA_W'(pb_q);
      A_AL:    a_op = OPA_W'(al_q);
      A_S:     a_op = OPA_W'(s_q);
      A_PDIFF: a_op = OPA_W'(pa_q) - OPA_W'(pb_q);
      A_RES:   a_op = OPA_W'(s_q) - OPA_W'(al_q);
      A_T:     a_op = t_q;
      default: a_op = t_q;
    endcase
  end

  // operand B: coefficient or mix amount
  always_comb begin
    unique case (ctrl_i.bsel)
      B_W_KEEP:  b_op = C_W_KEEP;
      B_W_IN:    b_op = C_W_IN;
      B_W_GAIN:  b_op = C_W_GAIN;
      B_PA_KEEP: b_op = C_PA_KEEP;
      B_PA_IN:   b_op = C_PA_IN;
      B_PB_KEEP: b_op = C_PB_KEEP;
      B_PB_IN:   b_op = C_PB_IN;
      B_P_GAIN:  b_op = C_P_GAIN;
      B_A_KEEP:  b_op = C_A_KEEP;
      B_A_IN:    b_op = C_A_IN;
      B_A_GAIN:  b_op = C_A_GAIN;
      B_AMT_W:   b_op = signed'(COEF_W'(amt_warmth_i));
      B_AMT_P:   b_op = signed'(COEF_W'(amt_presence_i));
      B_AMT_A:   b_op = signed'(COEF_W'(amt_air_i));
      default:   b_op = '0;
    endcase
  end

  // multiply-accumulate
  assign prod = PROD_W'(a_op) * PROD_W'(b_op);

  always_comb begin
    unique case (ctrl_i.mul)
      MUL_LOAD: acc_d = ACC_W'(prod);
      MUL_ADD:  acc_d = acc_q + ACC_W'(prod);
      default:  acc_d = acc_q;
    endcase
  end

  // round half up, drop the 16 fraction bits of the coefficient
  assign acc_half = acc_q + ACC_W'(ROUND_HALF);
  assign rnd      = acc_half[ACC_W-1:FRAC_BITS];
  assign s_sum    = SUM_W'(s_q) + SUM_W'(rnd);

  vte_sat #(.IN_W(RND_W), .OUT_W(STATE_BITS)) u_sat_filt (
    .x_i (rnd),
    .y_o (filt_sat)
  );

  vte_sat #(.IN_W(SUM_W), .OUT_W(STATE_BITS)) u_sat_sum (
    .x_i (s_sum),
    .y_o (sum_sat)
  );

  vte_sat #(.IN_W(RUN_W), .OUT_W(SAMPLE_BITS)) u_sat_out (
    .x_i (s_q),
    .y_o (sample_o)
  );

  // write-back
  always_comb begin
    s_d  = s_q;
    t_d  = t_q;
    wl_d = wl_q;
    pa_d = pa_q;
    pb_d = pb_q;
    al_d = al_q;
    if (load_i) begin
      s_d = RUN_W'(sample_i);
    end
    unique case (ctrl_i.wb)
      WB_WL:   wl_d = filt_sat;
      WB_PA:   pa_d = filt_sat;
      WB_PB:   pb_d = filt_sat;
      WB_AL:   al_d = filt_sat;
      WB_T:    t_d  = rnd[OPA_W-1:0];
      WB_S:    s_d  = RUN_W'(sum_sat);
      default: ;
    endcase
  end

  // working registers
  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    t_q   <= t_d;
    acc_q <= acc_d;
  end

  // filter states
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= '0;
      pa_q <= '0;
      pb_q <= '0;
      al_q <= '0;
    end else begin
      wl_q <= wl_d;
      pa_q <= pa_d;
      pb_q <= pb_d;
      al_q <= al_d;
    end
  end
endmodule

/* rtl/vocal_tone_enhancer.sv */
// ----------------------------------------------------------------------------
// vocal_tone_enhancer: three-stage vocal shaping filter
// Warmth, presence and air stages on a shared multiply-accumulate unit,
// run by a microprogram; one shaped sample out per sample in.
// ----------------------------------------------------------------------------
// One sample is taken when the block is idle and one saturated sample comes
// back for it, with the last-of-buffer mark copied through. The work is done
// by a microprogram on a single 18-bit-coefficient multiply-accumulate unit:
// after the transfer, 7 steps for warmth, 9 for presence and 5 for air
// when each is enabled (1 step when its amount is zero), plus 1 step to load
// the output register. The output register holds a finished sample while
// the next one is processed; the final step waits only if that register is
// still occupied. Amount writes above 1.0 are clamped to 1.0; writes must go
// in while idle, which the block itself does not enforce.
module vocal_tone_enhancer import vte_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int STATE_BITS  = STATE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  vte_in_if.sink               in_i,
  vte_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [AMT_W-1:0]     cfg_data_i
);
  logic [AMT_W-1:0]              warm_q, pres_q, air_q;
  logic [AMT_W-1:0]              cfg_clamped;
  amt_zero_t                     amt_zero;
  logic                          in_xfer;
  logic                          out_free;
  logic                          out_load;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          out_last_q;
  logic                          last_q;
  logic signed [SAMPLE_BITS-1:0] dp_sample;
  cw_t                           ctrl;

  // configuration registers, clamped to 1.0
  assign cfg_clamped = (cfg_data_i > AMT_ONE) ? AMT_ONE : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
      pres_q <= '0;
      air_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_WARMTH:   warm_q <= cfg_clamped;
        REG_PRESENCE: pres_q <= cfg_clamped;
        REG_AIR:      air_q  <= cfg_clamped;
        default: ;
      endcase
    end
  end

  assign amt_zero.warmth   = (warm_q == '0);
  assign amt_zero.presence = (pres_q == '0);
  assign amt_zero.air      = (air_q == '0);

  // handshakes
  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  vte_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .out_free_i (out_free),
    .amt_zero_i (amt_zero),
    .in_ready_o (in_i.ready),
    .ctrl_o     (ctrl),
    .out_load_o (out_load)
  );

  vte_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .STATE_BITS  (STATE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (in_xfer),
    .sample_i       (in_i.sample_in),
    .amt_warmth_i   (warm_q),
    .amt_presence_i (pres_q),
    .amt_air_i      (air_q),
    .ctrl_i         (ctrl),
    .sample_o       (dp_sample)
  );

  // last mark rides along with the sample
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      last_q <= in_i.frame_last;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= dp_sample;
      out_last_q   <= last_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_sample_q;
  assign out_o.out_last   = out_last_q;

  // checks
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_i.ready)
    else $error("input accepted again while an item is in progress");

  a_load_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_o.ready))
    else $error("result loaded over an untaken result");

  a_ready_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_i.ready) |-> $past(out_load))
    else $error("sequencer went idle without producing a result");

  a_amount_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm_q <= AMT_ONE) && (pres_q <= AMT_ONE) && (air_q <= AMT_ONE))
    else $error("amount register above 1.0");
endmodule
